/* rtl/core/bbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bbt_pkg;
  localparam int WINDOW_MAX = 64;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int PRICE_W    = 24;
  localparam int PADDR_W    = 3;
  localparam logic REG_WINDOW_LEN = 1'b0;
  localparam logic REG_BAND_GAIN  = 1'b1;
endpackage
`default_nettype wire

/* rtl/core/bbt_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
interface bbt_quote_if import bbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  modport source (output valid, price, input ready);
  modport sink (input valid, price, output ready);
endinterface

interface bbt_band_if import bbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ready_res;
  logic [23:0]        mid_band;
  logic [27:0]        upper_band;
  logic signed [28:0] lower_band;
  logic signed [23:0] percent_b;
  logic [23:0]        band_width;
  logic               flat;
  modport source (output valid, ready_res, mid_band, upper_band, lower_band, percent_b,
                  band_width, flat, input ready);
  modport sink (input valid, ready_res, mid_band, upper_band, lower_band, percent_b,
                band_width, flat, output ready);
endinterface
`default_nettype wire

/* rtl/core/bbt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bbt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/bollinger_band_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// bollinger band tracker
// quote channel: one price per beat (unsigned Q16.8); bands channel: one result beat
// per accepted price. apb port: window_len at 0x0, band_gain at 0x4; writing
// window_len restarts the window (sums, fill count and write slot cleared).
// until the window (window_len, held to 1..64) has filled the result carries ready_res 0 and zeros.
// steps: ring read and sum updates; once the window is full also the shift-add
// n*sumsq and sum^2, the bit-serial square root and four runs of the shared
// 48-step restoring divider (mean, deviation, %b, bandwidth).
// a new price is taken in the cycle after the result is loaded.
// one price is worked on at a time; the next is taken once the result sits in the
// output register, so a stalled receiver holds only that register and the block
// stops before loading a second result.
// reset: registers back to window 20, gain 2.0, empty window, no result pending.
// ring entries live in a 64-entry ram and are only read after being written.
module bollinger_band_tracker_unit import bbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  bbt_quote_if.sink               quote,
  bbt_band_if.source              bands
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_OLD  = 4'd2;
  localparam logic [3:0] S_NEW  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_VAR  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIVM = 4'd8;
  localparam logic [3:0] S_DIVS = 4'd9;
  localparam logic [3:0] S_OFF  = 4'd10;
  localparam logic [3:0] S_PREP = 4'd11;
  localparam logic [3:0] S_DIVP = 4'd12;
  localparam logic [3:0] S_DIVB = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]        state;
  logic [6:0]        window_len;
  logic [15:0]       band_gain;
  logic [SLOT_W-1:0] write_slot;
  logic [6:0]        fill_count;
  logic [29:0]       running_sum;
  logic [53:0]       running_square_sum;
  logic [23:0]       price_q;
  logic [SLOT_W-1:0] slot_cur;
  logic [47:0]       sq_tmp;
  logic              win_ok;
  logic [59:0]       sum_sq;
  logic [60:0]       acc;
  logic [5:0]        cnt;
  logic [23:0]       mid;
  logic [23:0]       sd;
  logic [27:0]       off;
  logic              pb_neg;
  logic [47:0]       pb_q;
  logic              pb_rnz;
  logic [47:0]       bw_q;

  logic [47:0] dv_q;
  logic [31:0] dv_rem;
  logic [30:0] dv_sor;
  logic [31:0] dv_sh;
  logic        dv_ge;
  logic [31:0] dv_rem_next;
  logic [47:0] dv_q_next;

  logic [61:0] sq_v;
  logic [33:0] sq_rem;
  logic [30:0] sq_root;
  logic [33:0] sq_sh;
  logic [33:0] sq_trial;
  logic        sq_ge;

  logic [6:0]        n_eff;
  logic [23:0]       rdata;
  logic              ram_we;
  logic              cfg_wr;
  logic              ring_full;
  logic [6:0]        slot_inc;
  logic [60:0]       acc_next;
  logic [59:0]       sum_sq_next;
  logic              out_load;
  logic signed [31:0] num;
  logic [29:0]       num_mag;
  logic [28:0]       up_raw;
  logic signed [29:0] lo_raw;
  logic [48:0]       pb_mag;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BAND_GAIN) ? {16'd0, band_gain} : {25'd0, window_len};

  always_comb begin
    if (window_len == 7'd0) n_eff = 7'd1;
    else if (window_len > 7'(WINDOW_MAX)) n_eff = 7'(WINDOW_MAX);
    else n_eff = window_len;
  end

  assign quote.ready = (state == S_IDLE);
  assign ring_full   = (fill_count >= n_eff);
  assign slot_inc    = {1'b0, slot_cur} + 7'd1;
  assign ram_we      = (state == S_OLD);
  assign out_load    = (state == S_FIN) && (!bands.valid || bands.ready);

  bbt_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_cur),
    .wdata (price_q),
    .raddr (slot_cur),
    .rdata (rdata)
  );

  // restoring divider step, one quotient bit per cycle
  assign dv_sh       = {dv_rem[30:0], dv_q[47]};
  assign dv_ge       = (dv_sh >= {1'b0, dv_sor});
  assign dv_rem_next = dv_ge ? (dv_sh - {1'b0, dv_sor}) : dv_sh;
  assign dv_q_next   = {dv_q[46:0], dv_ge};

  // square root step, two radicand bits per cycle
  assign sq_sh    = {sq_rem[31:0], sq_v[61:60]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  assign acc_next = {acc[59:0], 1'b0} + (n_eff[cnt[2:0]] ? {7'd0, running_square_sum} : 61'd0);
  // sum^2 by shift-add, one multiplier bit per cycle, msb first
  assign sum_sq_next = {sum_sq[58:0], 1'b0}
                       + (running_sum[cnt[4:0]] ? {30'd0, running_sum} : 60'd0);

  assign num     = $signed({8'd0, price_q}) + $signed({4'd0, off}) - $signed({8'd0, mid});
  assign num_mag = num[31] ? 30'(-num) : num[29:0];
  assign up_raw  = {5'd0, mid} + {1'b0, off};
  assign lo_raw  = $signed({6'd0, mid}) - $signed({2'd0, off});
  assign pb_mag  = {1'b0, pb_q} + {48'd0, pb_rnz};

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      window_len         <= 7'd20;
      band_gain          <= 16'd8192;
      write_slot         <= '0;
      fill_count         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      bands.valid        <= 1'b0;
    end else begin
      if (out_load) bands.valid <= 1'b1;
      else if (bands.ready) bands.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (quote.valid) begin
            price_q  <= quote.price;
            slot_cur <= ({1'b0, write_slot} >= n_eff) ? '0 : write_slot;
            state    <= S_RD;
          end
        end
        S_RD: state <= S_OLD;
        S_OLD: begin
          sq_tmp      <= ring_full ? (48'(rdata) * 48'(rdata)) : 48'd0;
          running_sum <= running_sum - (ring_full ? {6'd0, rdata} : 30'd0)
                         + {6'd0, price_q};
          if (!ring_full) fill_count <= fill_count + 7'd1;
          write_slot  <= (slot_inc >= n_eff) ? '0 : slot_inc[SLOT_W-1:0];
          state       <= S_NEW;
        end
        S_NEW: begin
          running_square_sum <= running_square_sum - {6'd0, sq_tmp};
          sq_tmp             <= 48'(price_q) * 48'(price_q);
          state              <= S_ADD;
        end
        S_ADD: begin
          running_square_sum <= running_square_sum + {6'd0, sq_tmp};
          sum_sq             <= '0;
          win_ok             <= ring_full;
          acc                <= '0;
          cnt                <= 6'd29;
          state              <= ring_full ? S_MUL : S_FIN;
        end
        S_MUL: begin
          sum_sq <= sum_sq_next;
          // n*sumsq only needs the last seven steps
          if (cnt < 6'd7) acc <= acc_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_VAR;
        end
        S_VAR: begin
          sq_v    <= (acc > {1'b0, sum_sq}) ? {1'b0, acc - {1'b0, sum_sq}} : 62'd0;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= 6'd30;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          sq_v    <= {sq_v[59:0], 2'b00};
          sq_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          sq_root <= {sq_root[29:0], sq_ge};
          cnt     <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            dv_q   <= {18'd0, running_sum};
            dv_rem <= '0;
            dv_sor <= {24'd0, n_eff};
            cnt    <= 6'd47;
            state  <= S_DIVM;
          end
        end
        S_DIVM: begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_rem_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            mid    <= dv_q_next[23:0];
            dv_q   <= {17'd0, sq_root};
            dv_rem <= '0;
            cnt    <= 6'd47;
            state  <= S_DIVS;
          end
        end
        S_DIVS: begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_rem_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            sd    <= dv_q_next[23:0];
            state <= S_OFF;
          end
        end
        S_OFF: begin
          off   <= 28'((40'(band_gain) * 40'(sd)) >> 12);
          state <= S_PREP;
        end
        S_PREP: begin
          pb_neg <= num[31];
          dv_q   <= {2'd0, num_mag, 16'd0};
          dv_rem <= '0;
          dv_sor <= {2'd0, off, 1'b0};
          cnt    <= 6'd47;
          state  <= S_DIVP;
        end
        S_DIVP: begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_rem_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            pb_q   <= dv_q_next;
            pb_rnz <= (dv_rem_next != 32'd0);
            dv_q   <= {3'd0, off, 1'b0, 16'd0};
            dv_rem <= '0;
            dv_sor <= (mid != 24'd0) ? {7'd0, mid} : 31'd256;
            cnt    <= 6'd47;
            state  <= S_DIVB;
          end
        end
        S_DIVB: begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_rem_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            bw_q  <= dv_q_next;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            bands.ready_res <= win_ok;
            if (!win_ok) begin
              bands.mid_band   <= '0;
              bands.upper_band <= '0;
              bands.lower_band <= '0;
              bands.percent_b  <= '0;
              bands.band_width <= '0;
              bands.flat       <= 1'b0;
            end else begin
              bands.mid_band   <= mid;
              bands.upper_band <= (up_raw > 29'h0FFFFFFF) ? 28'hFFFFFFF : up_raw[27:0];
              bands.lower_band <= (lo_raw < -30'sd268435456) ? -29'sd268435456
                                                             : lo_raw[28:0];
              bands.flat       <= (off == 28'd0);
              // floor toward minus infinity for negative positions
              if (off == 28'd0) bands.percent_b <= '0;
              else if (!pb_neg)
                bands.percent_b <= (pb_q > 48'd8388607) ? 24'sh7FFFFF : pb_q[23:0];
              else
                bands.percent_b <= (pb_mag > 49'd8388608) ? 24'sh800000
                                                          : 24'(-pb_mag);
              bands.band_width <= (bw_q > 48'hFFFFFF) ? 24'hFFFFFF : bw_q[23:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        if (paddr[2] == REG_WINDOW_LEN) begin
          window_len         <= pwdata[6:0];
          write_slot         <= '0;
          fill_count         <= '0;
          running_sum        <= '0;
          running_square_sum <= '0;
        end else begin
          band_gain <= pwdata[15:0];
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill_count <= n_eff)
    else $error("fill count beyond window length");
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    bands.valid && bands.flat |-> bands.percent_b == 24'sd0)
    else $error("flat band with nonzero percent_b");
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    bands.valid && !bands.ready_res |-> bands.mid_band == 24'd0 && bands.upper_band == 28'd0)
    else $error("result fields set while window not full");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    quote.valid && quote.ready |=> !quote.ready)
    else $error("second price taken while busy");
endmodule
`default_nettype wire

/* sim/bollinger_band_tracker_unit_tb.sv */
`timescale 1ns / 1ps
module bollinger_band_tracker_unit_tb;
  import bbt_pkg::*;

  typedef struct packed {
    logic               ready_res;
    logic [23:0]        mid_band;
    logic [27:0]        upper_band;
    logic signed [28:0] lower_band;
    logic signed [23:0] percent_b;
    logic [23:0]        band_width;
    logic               flat;
  } band_t;

  typedef enum int {ROW_CFG, ROW_PRICE, ROW_TYPED} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [31:0]        data;
    logic [23:0]        price;
    band_t              bands;
  } row_t;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_BAND_GAIN  = {REG_BAND_GAIN, 2'b00};
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_FROM = 1330;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bbt_quote_if quote_ch ();
  bbt_band_if band_ch ();

  bollinger_band_tracker_unit u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .quote(quote_ch), .bands(band_ch)
  );

  always #1 clk = ~clk;

  // band model state
  logic [23:0] ring_mem [WINDOW_MAX];
  int unsigned head_slot;
  int unsigned fill_cnt;
  logic [63:0] win_sum;
  logic [63:0] win_sqsum;
  logic [6:0]  cur_window;
  logic [15:0] cur_gain;

  band_t pending_bands[$];
  row_t  rows[$];
  int    fail_cnt = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;
  int    stall_left = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic band_t track_price(logic [23:0] p);
    band_t r;
    int unsigned n;
    int unsigned slot;
    logic [63:0] old, lsum, lsq, dvar, m, sd, offu;
    longint off, up, lo, spread, pctb, bw, dv;
    r = '0;
    n = (cur_window == 0) ? 1 : (cur_window > WINDOW_MAX) ? WINDOW_MAX : cur_window;
    slot = head_slot;
    if (slot >= n) slot = 0;
    if (fill_cnt >= n) begin
      old = ring_mem[slot];
      win_sum = win_sum - old;
      win_sqsum = win_sqsum - old * old;
    end else begin
      fill_cnt++;
    end
    ring_mem[slot] = p;
    win_sum = win_sum + p;
    win_sqsum = win_sqsum + 64'(p) * 64'(p);
    slot++;
    head_slot = (slot >= n) ? 0 : slot;
    if (fill_cnt < n) return r;
    lsum = 64'(n) * win_sqsum;
    lsq = win_sum * win_sum;
    dvar = (lsum > lsq) ? lsum - lsq : 0;
    m = win_sum / n;
    sd = int_sqrt(dvar) / n;
    offu = (64'(cur_gain) * sd) >> 12;
    off = longint'(offu);
    up = longint'(m) + off;
    lo = longint'(m) - off;
    spread = 2 * off;
    dv = (m != 0) ? longint'(m) : 256;
    pctb = 0;
    if (off != 0) begin
      pctb = floor_quot((longint'(p) - lo) * 65536, spread);
      if (pctb > 8388607) pctb = 8388607;
      if (pctb < -8388608) pctb = -8388608;
    end
    bw = (spread * 65536) / dv;
    if (bw > 16777215) bw = 16777215;
    if (up > 268435455) up = 268435455;
    if (lo < -268435456) lo = -268435456;
    r.ready_res = 1'b1;
    r.mid_band = m[23:0];
    r.upper_band = up[27:0];
    r.lower_band = lo[28:0];
    r.percent_b = pctb[23:0];
    r.band_width = bw[23:0];
    r.flat = (off == 0);
    return r;
  endfunction

  function automatic void model_write(logic [PADDR_W-1:0] a, logic [31:0] d);
    if (a == ADDR_WINDOW_LEN) begin
      cur_window = d[6:0];
      head_slot = 0;
      fill_cnt = 0;
      win_sum = 0;
      win_sqsum = 0;
    end else if (a == ADDR_BAND_GAIN) begin
      cur_gain = d[15:0];
    end
  endfunction

  task automatic apb_write(logic [PADDR_W-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_write(a, d);
  endtask

  // all beats out, then let the block settle before touching registers
  task automatic settle();
    quote_ch.valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_price(logic [23:0] p, bit typed, band_t typed_bands);
    band_t b;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      quote_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    quote_ch.valid <= 1'b1;
    quote_ch.price <= p;
    do @(posedge clk); while (!quote_ch.ready);
    b = track_price(p);
    if (typed) b = typed_bands;
    pending_bands.insert(pending_bands.size(), b);
  endtask

  function automatic void add_cfg(logic [PADDR_W-1:0] a, logic [31:0] d);
    row_t r;
    r = '{kind: ROW_CFG, addr: a, data: d, price: '0, bands: '0};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_price(logic [23:0] p);
    row_t r;
    r = '{kind: ROW_PRICE, addr: '0, data: '0, price: p, bands: '0};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_typed(logic [23:0] p, band_t b);
    row_t r;
    r = '{kind: ROW_TYPED, addr: '0, data: '0, price: p, bands: b};
    rows.insert(rows.size(), r);
  endfunction

  function automatic logic [23:0] pick_price(int mode, logic [23:0] base);
    case (mode)
      0: return 24'($urandom_range(0, 24'hFFFFFF));
      1: return 24'(base + $urandom_range(0, 255));
      2: return ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 24'hFFFFFF)) : base;
      default: return ($urandom_range(0, 15) == 0) ? 24'($urandom_range(0, 80)) : 24'd0;
    endcase
  endfunction

  // receiver side: ready drops in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      band_ch.ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13);
      band_ch.ready <= 1'b0;
    end else begin
      band_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    band_t got, want;
    if (!rst && band_ch.valid && band_ch.ready) begin
      got = '{band_ch.ready_res, band_ch.mid_band, band_ch.upper_band, band_ch.lower_band,
              band_ch.percent_b, band_ch.band_width, band_ch.flat};
      if (pending_bands.size() == 0) begin
        $display("%0t: band beat with none expected: %p", $time, got);
        fail_cnt++;
      end else begin
        want = pending_bands[0];
        pending_bands.delete(0);
        if (got.ready_res !== want.ready_res) begin
          $display("%0t: ready_res exp %0d got %0d", $time, want.ready_res, got.ready_res);
          fail_cnt++;
        end
        if (got.mid_band !== want.mid_band) begin
          $display("%0t: mid_band exp %0d got %0d", $time, want.mid_band, got.mid_band);
          fail_cnt++;
        end
        if (got.upper_band !== want.upper_band) begin
          $display("%0t: upper_band exp %0d got %0d", $time, want.upper_band, got.upper_band);
          fail_cnt++;
        end
        if (got.lower_band !== want.lower_band) begin
          $display("%0t: lower_band exp %0d got %0d", $time, want.lower_band, got.lower_band);
          fail_cnt++;
        end
        if (got.percent_b !== want.percent_b) begin
          $display("%0t: percent_b exp %0d got %0d", $time, want.percent_b, got.percent_b);
          fail_cnt++;
        end
        if (got.band_width !== want.band_width) begin
          $display("%0t: band_width exp %0d got %0d", $time, want.band_width, got.band_width);
          fail_cnt++;
        end
        if (got.flat !== want.flat) begin
          $display("%0t: flat exp %0d got %0d", $time, want.flat, got.flat);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((quote_ch.valid && quote_ch.ready) || (band_ch.valid && band_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int plen;
    int mode;
    int sel;
    logic [23:0] base;
    logic [31:0] wl, gn;
    quote_ch.valid <= 1'b0;
    quote_ch.price <= '0;
    cur_window = 7'd20;
    cur_gain = 16'd8192;
    head_slot = 0;
    fill_cnt = 0;
    win_sum = 0;
    win_sqsum = 0;

    // window not yet full after reset
    add_typed(24'd0, '0);
    add_typed(24'hFFFFFF, '0);
    // single-entry window: no spread, flat band
    add_cfg(ADDR_WINDOW_LEN, 32'd1);
    add_typed(24'hFFFFFF, '{1'b1, 24'hFFFFFF, 28'hFFFFFF, 29'sh0FFFFFF, 24'sd0, 24'd0, 1'b1});
    add_typed(24'd0, '{1'b1, 24'd0, 28'd0, 29'sd0, 24'sd0, 24'd0, 1'b1});
    add_cfg(ADDR_BAND_GAIN, 32'd65535);
    add_cfg(ADDR_WINDOW_LEN, 32'd2);
    add_price(24'd0);
    add_price(24'hFFFFFF);
    add_price(24'hFFFFFF);
    add_price(24'd0);
    add_price(24'h000100);
    add_cfg(ADDR_BAND_GAIN, 32'd0);
    add_price(24'd5);
    add_price(24'd1000);
    add_cfg(ADDR_BAND_GAIN, 32'd8192);
    add_cfg(ADDR_WINDOW_LEN, 32'd0);
    add_price(24'h800000);
    add_price(24'h7FFFFF);
    add_cfg(ADDR_WINDOW_LEN, 32'd127);
    add_price(24'h123456);
    add_price(24'hABCDEF);
    add_cfg(ADDR_WINDOW_LEN, 32'd3);
    add_price(24'd0);
    add_price(24'd7);
    add_price(24'd0);
    add_price(24'hFFFFFF);
    add_price(24'd1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        apb_write(rows[i].addr, rows[i].data);
      end else begin
        send_price(rows[i].price, rows[i].kind == ROW_TYPED, rows[i].bands);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      sel = $urandom_range(0, 9);
      wl = (sel == 0) ? 0 : (sel == 1) ? 64 : (sel == 2) ? $urandom_range(65, 127) :
           (sel == 3) ? 1 : $urandom_range(2, 8);
      sel = $urandom_range(0, 5);
      gn = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 65535);
      mode = $urandom_range(0, 3);
      // sparse small prices give a zero mean with a nonzero band in a long window
      if (mode == 3) wl = 64;
      if ($urandom_range(0, 3) != 0) apb_write(ADDR_BAND_GAIN, gn);
      if ($urandom_range(0, 5) != 0) apb_write(ADDR_WINDOW_LEN, wl);
      base = 24'($urandom_range(0, 24'hFFFF00));
      plen = $urandom_range(90, 200);
      if (plen > RANDOM_ITEMS - sent) plen = RANDOM_ITEMS - sent;
      repeat (plen) begin
        if (sent >= QUIET_FROM) quiet = 1'b1;
        send_price(pick_price(mode, base), 1'b0, '0);
        sent++;
      end
    end

    quote_ch.valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/bbt_pkg.sv
rtl/core/bbt_ifs.sv
rtl/core/bbt_ram.sv
rtl/core/bollinger_band_tracker_unit.sv
sim/bollinger_band_tracker_unit_tb.sv
